[hdl/mtf_pkg.sv]
`default_nettype none
package mtf_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = 5;
    localparam int VAL_W = 32;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_SEARCH = 2'd1,
        REQ_GET    = 2'd2,
        REQ_REMOVE = 2'd3
    } req_e_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_req;
        logic exec;
    } mtf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } mtf_status_t;

endpackage
`default_nettype wire

[hdl/mtf_ctrl.sv]
`default_nettype none
module mtf_ctrl
    import mtf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire mtf_status_t status,
    output mtf_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.load_req = 1'b0;
        cmd.exec     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // wait for a free result slot
                if (status.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[hdl/mtf_dpath.sv]
`default_nettype none
module mtf_dpath
    import mtf_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire mtf_cmd_t                cmd,
    output mtf_status_t                  status,
    input  wire logic [1:0]              req_type,
    input  wire logic [CNT_W-1:0]        position,
    input  wire logic signed [VAL_W-1:0] item_value,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [CNT_W-1:0]             found_position,
    output logic signed [VAL_W-1:0]      read_value,
    output logic [CNT_W-1:0]             entry_count,
    output logic                         bad_request
);

    // request word
    req_e_t                  req_reg;
    logic [CNT_W-1:0]        pos_reg;
    logic [VAL_W-1:0]        val_reg;

    // list cells, front at index 0
    logic [VAL_W-1:0]        cells_reg [DEPTH];
    logic [VAL_W-1:0]        cells_next [DEPTH];
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;

    // result word
    logic                    out_valid_reg;
    logic [CNT_W-1:0]        found_reg;
    logic [VAL_W-1:0]        read_reg;
    logic                    bad_reg;

    logic                    full;
    logic                    ins_ok;
    logic                    rd_ok;
    logic [IDX_W-1:0]        k;
    logic [DEPTH-1:0]        match;
    logic                    hit_any;
    logic [IDX_W-1:0]        hit_idx;
    logic [CNT_W-1:0]        found_next;
    logic [VAL_W-1:0]        read_next;
    logic                    bad_next;
    logic [CNT_W-1:0]        pos_m1;

    assign status.out_free = !out_valid_reg || out_ready;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign pos_m1 = pos_reg - CNT_W'(1);

    // insert into an empty list goes to the front whatever the position
    assign ins_ok = !full &&
                    ((count_reg == '0) ||
                     ((pos_reg != '0) &&
                      ({1'b0, pos_reg} <= ({1'b0, count_reg} + (CNT_W + 1)'(1)))));
    assign rd_ok  = (pos_reg != '0) && (pos_reg <= count_reg);
    assign k      = (count_reg == '0) ? '0 : pos_m1[IDX_W-1:0];

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            match[i] = (CNT_W'(i) < count_reg) && (cells_reg[i] == val_reg);
        end
    end

    // first match from the front
    always_comb
    begin
        hit_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign hit_any = |match;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cells_next[i] = cells_reg[i];
        end
        count_next = count_reg;
        found_next = '0;
        read_next  = '0;
        bad_next   = 1'b0;
        unique case (req_reg)
            REQ_INSERT:
            begin
                if (ins_ok)
                begin
                    count_next = count_reg + CNT_W'(1);
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (IDX_W'(i) == k)
                        begin
                            cells_next[i] = val_reg;
                        end
                        else if ((i > 0) && (IDX_W'(i) > k))
                        begin
                            cells_next[i] = cells_reg[(i > 0) ? i - 1 : 0];
                        end
                    end
                end
                else
                begin
                    bad_next = 1'b1;
                end
            end
            REQ_SEARCH:
            begin
                if (hit_any)
                begin
                    found_next = CNT_W'(hit_idx) + CNT_W'(1);
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (i == 0)
                        begin
                            cells_next[i] = val_reg;
                        end
                        else if (IDX_W'(i) <= hit_idx)
                        begin
                            cells_next[i] = cells_reg[(i > 0) ? i - 1 : 0];
                        end
                    end
                end
            end
            REQ_GET:
            begin
                if (rd_ok)
                begin
                    read_next = cells_reg[k];
                end
                else
                begin
                    bad_next = 1'b1;
                end
            end
            REQ_REMOVE:
            begin
                if (rd_ok)
                begin
                    count_next = count_reg - CNT_W'(1);
                    for (int i = 0; i < DEPTH - 1; i++)
                    begin
                        if (IDX_W'(i) >= k)
                        begin
                            cells_next[i] = cells_reg[i + 1];
                        end
                    end
                end
                else
                begin
                    bad_next = 1'b1;
                end
            end
            default:
            begin
                bad_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req_e_t'(req_type);
            pos_reg <= position;
            val_reg <= item_value;
        end
        if (cmd.exec)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                cells_reg[i] <= cells_next[i];
            end
            found_reg <= found_next;
            read_reg  <= read_next;
            bad_reg   <= bad_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign found_position = found_reg;
    assign read_value     = read_reg;
    assign entry_count    = count_reg;
    assign bad_request    = bad_reg;

endmodule
`default_nettype wire

[hdl/move_to_front_list.sv]
// Move-to-front list: an ordered list of up to 16 signed 32-bit values
// held in a row of registers, front at entry 0.
// Input channel (in_valid/in_ready): one request word of req_type,
//   position and item_value. Insert, search-and-move-to-front, get, remove.
// Output channel (out_valid/out_ready): one result word per request:
//   found_position, read_value, entry_count and bad_request.
// Order: the request word is registered when accepted; the result is
//   registered in the execute state, which holds while an earlier result
//   still waits on the output. The controller takes a word in its idle
//   state and executes it in the next, where every cell compares and
//   shifts at once; it takes no new request before executing that one.
// Stall: the result sits in an output register. A request is still taken
//   while a result waits; it is executed once that result leaves, and the
//   input stays blocked meanwhile.
// Reset: clears the entry count and drops out_valid; cell contents are
//   not cleared and are only read below the count.
// Out-of-range positions (save an insert into an empty list) and inserts
//   into a full list set bad_request and leave the list unchanged.
`default_nettype none
module move_to_front_list
    import mtf_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [1:0]              req_type,
    input  wire logic [CNT_W-1:0]        position,
    input  wire logic signed [VAL_W-1:0] item_value,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [CNT_W-1:0]             found_position,
    output logic signed [VAL_W-1:0]      read_value,
    output logic [CNT_W-1:0]             entry_count,
    output logic                         bad_request
);

    mtf_cmd_t    cmd;
    mtf_status_t status;

    // sequencer: idle / execute
    mtf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // cells, compare/shift network and result register
    mtf_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .req_type       (req_type),
        .position       (position),
        .item_value     (item_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found_position (found_position),
        .read_value     (read_value),
        .entry_count    (entry_count),
        .bad_request    (bad_request)
    );

endmodule
`default_nettype wire
